@@ sv/ils_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and constants of the indexed list shift store
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 8;
  localparam int unsigned DataW    = 32;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // one port of the entry store: one write and one read address per cycle
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // finished result of one request
  typedef struct packed {
    logic [DataW-1:0]  read_value;
    status_e           status;
    logic [CountW-1:0] item_count;
  } result_t;

endpackage

@@ sv/ils_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_store
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ils_store (
  input  logic                            clk_i,
  input  ils_pkg::mem_req_t               mem_req_i,
  output logic [ils_pkg::DataW-1:0]       rdata_o
);

  logic [ils_pkg::DataW-1:0] mem [ils_pkg::Capacity];
  logic [ils_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_q <= mem[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ils_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ctrl
// request sequencer: range checks, count, and entry shifting over the store
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic [2:0]                     req_type_i,
  input  logic [ils_pkg::PosW-1:0]       position_i,
  input  logic [ils_pkg::DataW-1:0]      new_value_i,
  output ils_pkg::mem_req_t              mem_req_o,
  input  logic [ils_pkg::DataW-1:0]      rdata_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output ils_pkg::result_t               res_o
);

  localparam int unsigned AW = ils_pkg::AddrW;
  localparam int unsigned CW = ils_pkg::CountW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET_WAIT,
    S_INS_SHIFT,
    S_INS_FILL,
    S_REM_READ,
    S_REM_SHIFT,
    S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [2:0]                op_q, op_d;
  logic [ils_pkg::PosW-1:0]  pos_q, pos_d;
  logic [ils_pkg::DataW-1:0] val_q, val_d;
  logic [CW-1:0]             ptr_q, ptr_d;
  logic [CW-1:0]             count_q, count_d;
  ils_pkg::result_t          res_q, res_d;

  logic [CW-1:0] pos_ext, pos_p1, cnt_m1, ptr_m1, ptr_m2, ptr_p1, ptr_p2;
  logic          in_range, full;
  logic          fin;
  logic [ils_pkg::DataW-1:0] fin_rd;
  ils_pkg::status_e          fin_st;

  assign pos_ext  = CW'(pos_q);
  assign pos_p1   = pos_ext + CW'(1);
  assign cnt_m1   = count_q - CW'(1);
  assign ptr_m1   = ptr_q - CW'(1);
  assign ptr_m2   = ptr_q - CW'(2);
  assign ptr_p1   = ptr_q + CW'(1);
  assign ptr_p2   = ptr_q + CW'(2);
  assign in_range = pos_ext < count_q;
  assign full     = count_q == CW'(ils_pkg::Capacity);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    res_d     = res_q;
    mem_req_o = '0;
    fin       = 1'b0;
    fin_rd    = '0;
    fin_st    = ils_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_type_i;
          pos_d   = position_i;
          val_d   = new_value_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_q)
          ils_pkg::OP_GET: begin
            if (in_range) begin
              mem_req_o.raddr = pos_ext[AW-1:0];
              state_d         = S_GET_WAIT;
            end else begin
              fin    = 1'b1;
              fin_st = ils_pkg::ST_RANGE;
            end
          end
          ils_pkg::OP_SET: begin
            fin = 1'b1;
            if (in_range) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = pos_ext[AW-1:0];
              mem_req_o.wdata = val_q;
            end else begin
              fin_st = ils_pkg::ST_RANGE;
            end
          end
          ils_pkg::OP_APPEND: begin
            fin = 1'b1;
            if (full) begin
              fin_st = ils_pkg::ST_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = count_q[AW-1:0];
              mem_req_o.wdata = val_q;
              count_d         = count_q + CW'(1);
            end
          end
          ils_pkg::OP_INSERT: begin
            if (!in_range) begin
              fin    = 1'b1;
              fin_st = ils_pkg::ST_RANGE;
            end else if (full) begin
              fin    = 1'b1;
              fin_st = ils_pkg::ST_FULL;
            end else begin
              // walk down from the tail, one entry moved up per cycle
              mem_req_o.raddr = cnt_m1[AW-1:0];
              ptr_d           = count_q;
              state_d         = S_INS_SHIFT;
            end
          end
          ils_pkg::OP_REMOVE: begin
            if (in_range) begin
              mem_req_o.raddr = pos_ext[AW-1:0];
              state_d         = S_REM_READ;
            end else begin
              fin    = 1'b1;
              fin_st = ils_pkg::ST_RANGE;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_GET_WAIT: begin
        fin    = 1'b1;
        fin_rd = rdata_i;
      end

      S_INS_SHIFT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[AW-1:0];
        mem_req_o.wdata = rdata_i;
        if (ptr_q == pos_p1) begin
          state_d = S_INS_FILL;
        end else begin
          mem_req_o.raddr = ptr_m2[AW-1:0];
          ptr_d           = ptr_m1;
        end
      end

      S_INS_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_ext[AW-1:0];
        mem_req_o.wdata = val_q;
        count_d         = count_q + CW'(1);
        fin             = 1'b1;
      end

      S_REM_READ: begin
        // removed entry kept in the value register until the shift ends
        val_d = rdata_i;
        if (pos_p1 >= count_q) begin
          count_d = cnt_m1;
          fin     = 1'b1;
          fin_rd  = rdata_i;
        end else begin
          mem_req_o.raddr = pos_p1[AW-1:0];
          ptr_d           = pos_ext;
          state_d         = S_REM_SHIFT;
        end
      end

      S_REM_SHIFT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[AW-1:0];
        mem_req_o.wdata = rdata_i;
        if (ptr_p2 >= count_q) begin
          count_d = cnt_m1;
          fin     = 1'b1;
          fin_rd  = val_q;
        end else begin
          mem_req_o.raddr = ptr_p2[AW-1:0];
          ptr_d           = ptr_p1;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      res_d.read_value = fin_rd;
      res_d.status     = fin_st;
      res_d.item_count = count_d;
      state_d          = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      op_q    <= '0;
      pos_q   <= '0;
      val_q   <= '0;
      ptr_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      op_q    <= op_d;
      pos_q   <= pos_d;
      val_q   <= val_d;
      ptr_q   <= ptr_d;
      res_q   <= res_d;
    end
  end

  assign req_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

endmodule

@@ sv/indexed_list_shift_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_shift_store
// fixed-capacity list of signed 32-bit entries with get, set, append,
// insert-before and remove requests
// ----------------------------------------------------------------------------
//
//   channel   signals                                      direction
//   --------  -------------------------------------------  ---------
//   request   in_valid_i / in_ready_o, req_type_i,          in
//             position_i, new_value_i
//   result    out_valid_o / out_ready_i, read_value_o,      out
//             status_o, item_count_o
//
// insert and remove shift the entries above the position one at a time, since
//   the single store write port moves one entry per cycle
// one request is in work at a time; a new request is taken as soon as the
//   sequencer is idle, even while the last result waits in the output register
// reset clears the count and the handshakes; the store itself is not cleared,
//   since only entries below the count are ever read
// a stalled result holds the sequencer in its done state, so nothing is lost
// ----------------------------------------------------------------------------
module indexed_list_shift_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        req_type_i,
  input  logic [7:0]                        position_i,
  input  logic signed [31:0]                new_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                read_value_o,
  output logic [1:0]                        status_o,
  output logic [ils_pkg::CountW-1:0]        item_count_o
);

  ils_pkg::mem_req_t           mem_req;
  logic [ils_pkg::DataW-1:0]   rdata;
  logic                        res_valid;
  logic                        res_ready;
  ils_pkg::result_t            res;

  // output register, parts the sequencer from the result consumer
  logic                        out_valid_q;
  ils_pkg::result_t            out_q;

  // entry store
  ils_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  // request sequencer with the shift loop
  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .new_value_i (new_value_i),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // load a new result when the register is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q.read_value;
  assign status_o     = out_q.status;
  assign item_count_o = out_q.item_count;

endmodule

@@ tb/indexed_list_shift_store_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_shift_store_tb
// checks every result of the list store against a cycle-free list model
// ----------------------------------------------------------------------------
//
// requests are planned into a queue by the stimulus block and handed to the
// block by a clocked driver with random gaps; each accepted request is applied
// to a shadow list at once, and the result it yields waits in a queue until
// the monitor takes the block's result and compares it field by field
// phases: directed corner requests, a random mix, a mix with no idling, then
// a fill to capacity with requests on the full list
// ----------------------------------------------------------------------------
module indexed_list_shift_store_tb;

  // request codes the block treats as no operation
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pos;
    logic [31:0] val;
  } list_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       req_valid = 1'b0;
  logic                       req_ready;
  list_req_t                  cur_req   = '0;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  logic signed [31:0]         read_value;
  logic [1:0]                 status;
  logic [ils_pkg::CountW-1:0] item_count;

  list_req_t         req_queue[$];
  ils_pkg::result_t  due_replies[$];
  int                idle_pct   = 18;
  int                mismatches = 0;
  int unsigned       gen_len    = 0;

  // shadow list, updated once per accepted request
  logic [31:0]                list_mem[0:ils_pkg::Capacity-1];
  logic [ils_pkg::CountW-1:0] list_len = '0;

  indexed_list_shift_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_valid),
    .in_ready_o   (req_ready),
    .req_type_i   (cur_req.kind),
    .position_i   (cur_req.pos),
    .new_value_i  (cur_req.val),
    .out_valid_o  (res_valid),
    .out_ready_i  (res_ready),
    .read_value_o (read_value),
    .status_o     (status),
    .item_count_o (item_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  // applies one request to the shadow list and returns its result
  function automatic ils_pkg::result_t apply_list_request(input list_req_t req);
    ils_pkg::result_t r;
    logic             in_range;
    r.read_value = '0;
    r.status     = ils_pkg::ST_OK;
    in_range     = req.pos < list_len;
    case (req.kind)
      ils_pkg::OP_GET: begin
        if (in_range) r.read_value = list_mem[req.pos];
        else r.status = ils_pkg::ST_RANGE;
      end
      ils_pkg::OP_SET: begin
        if (in_range) list_mem[req.pos] = req.val;
        else r.status = ils_pkg::ST_RANGE;
      end
      ils_pkg::OP_APPEND: begin
        if (list_len >= ils_pkg::Capacity) begin
          r.status = ils_pkg::ST_FULL;
        end else begin
          list_mem[list_len[ils_pkg::AddrW-1:0]] = req.val;
          list_len++;
        end
      end
      ils_pkg::OP_INSERT: begin
        // position is checked before fullness
        if (!in_range) begin
          r.status = ils_pkg::ST_RANGE;
        end else if (list_len >= ils_pkg::Capacity) begin
          r.status = ils_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > req.pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[req.pos] = req.val;
          list_len++;
        end
      end
      ils_pkg::OP_REMOVE: begin
        if (!in_range) begin
          r.status = ils_pkg::ST_RANGE;
        end else begin
          r.read_value = list_mem[req.pos];
          for (int i = req.pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.item_count = list_len;
    return r;
  endfunction

  // request driver: holds a request until taken, then maybe idles
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic hold;
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      hold = req_valid && !req_ready;
      if (req_valid && req_ready) due_replies = {due_replies, apply_list_request(cur_req)};
      if (!hold) begin
        if (req_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_req   <= req_queue.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ils_pkg::result_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (due_replies.size() == 0) begin
          flag_mismatch("result with no request", read_value, '0);
        end else begin
          want = due_replies.pop_front();
          if (read_value !== want.read_value)
            flag_mismatch("read_value", read_value, want.read_value);
          if (status !== want.status)
            flag_mismatch("status", 32'(status), 32'(want.status));
          if (item_count !== want.item_count)
            flag_mismatch("item_count", 32'(item_count), 32'(want.item_count));
        end
      end
      res_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // plans a request and tracks the list length it leads to
  task automatic queue_req(input logic [2:0] kind, input logic [7:0] pos,
                           input logic [31:0] val);
    list_req_t req;
    req.kind  = kind;
    req.pos   = pos;
    req.val   = val;
    req_queue = {req_queue, req};
    case (kind)
      ils_pkg::OP_APPEND: if (gen_len < ils_pkg::Capacity) gen_len++;
      ils_pkg::OP_INSERT: if (pos < gen_len && gen_len < ils_pkg::Capacity) gen_len++;
      ils_pkg::OP_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic queue_random();
    int         pick;
    logic [2:0] kind;
    logic [7:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 20) kind = ils_pkg::OP_GET;
    else if (pick < 35) kind = ils_pkg::OP_SET;
    else if (pick < 60) kind = ils_pkg::OP_APPEND;
    else if (pick < 75) kind = ils_pkg::OP_INSERT;
    else if (pick < 95) kind = ils_pkg::OP_REMOVE;
    else begin
      case ($urandom_range(0, 2))
        0: kind = OP_SPARE_A;
        1: kind = OP_SPARE_B;
        default: kind = OP_SPARE_C;
      endcase
    end
    // mostly valid positions, the rest anywhere in the field
    if (gen_len != 0 && $urandom_range(0, 9) < 8) pos = 8'($urandom_range(0, gen_len - 1));
    else pos = 8'($urandom);
    queue_req(kind, pos, $urandom);
  endtask

  // sender pause: wait until every planned request has its result
  task automatic drain();
    while (req_queue.size() != 0 || req_valid || due_replies.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, value extremes, list edges, spare codes
    queue_req(ils_pkg::OP_GET,    8'd0,   32'h0);
    queue_req(ils_pkg::OP_REMOVE, 8'd0,   32'h0);
    queue_req(ils_pkg::OP_INSERT, 8'd0,   32'h1111_1111);
    queue_req(ils_pkg::OP_SET,    8'd0,   32'h2222_2222);
    queue_req(ils_pkg::OP_APPEND, 8'd0,   32'h8000_0000);
    queue_req(ils_pkg::OP_APPEND, 8'd255, 32'h7fff_ffff);
    queue_req(ils_pkg::OP_APPEND, 8'd0,   32'h0000_0000);
    queue_req(ils_pkg::OP_APPEND, 8'd0,   32'hffff_ffff);
    queue_req(ils_pkg::OP_GET,    8'd0,   32'h0);
    queue_req(ils_pkg::OP_GET,    8'd3,   32'h0);
    queue_req(ils_pkg::OP_GET,    8'd4,   32'h0);
    queue_req(ils_pkg::OP_SET,    8'd1,   32'h5a5a_5a5a);
    queue_req(ils_pkg::OP_GET,    8'd1,   32'h0);
    queue_req(ils_pkg::OP_INSERT, 8'd0,   32'ha5a5_a5a5);
    queue_req(ils_pkg::OP_INSERT, 8'd4,   32'h1234_5678);
    queue_req(ils_pkg::OP_INSERT, 8'd6,   32'hdead_beef);
    queue_req(ils_pkg::OP_REMOVE, 8'd0,   32'h0);
    queue_req(ils_pkg::OP_REMOVE, 8'd4,   32'h0);
    queue_req(ils_pkg::OP_GET,    8'd255, 32'h0);
    queue_req(ils_pkg::OP_SET,    8'd255, 32'hffff_ffff);
    queue_req(OP_SPARE_A, 8'd255, 32'hffff_ffff);
    queue_req(OP_SPARE_B, 8'd0,   32'h0);
    queue_req(OP_SPARE_C, 8'd170, 32'h5555_5555);
    drain();

    repeat (100) queue_random();
    drain();

    // stretch with no idling on either side
    idle_pct <= 0;
    repeat (40) queue_random();
    drain();
    idle_pct <= 18;

    // fill to capacity, then requests on a full list
    while (gen_len < ils_pkg::Capacity)
      queue_req(ils_pkg::OP_APPEND, 8'($urandom), $urandom);
    queue_req(ils_pkg::OP_APPEND, 8'd0,   $urandom);
    queue_req(ils_pkg::OP_APPEND, 8'd255, $urandom);
    queue_req(ils_pkg::OP_INSERT, 8'($urandom), $urandom);
    queue_req(ils_pkg::OP_INSERT, 8'd255, $urandom);
    queue_req(ils_pkg::OP_INSERT, 8'd0,   $urandom);
    queue_req(ils_pkg::OP_GET,    8'd255, 32'h0);
    queue_req(ils_pkg::OP_SET,    8'd255, $urandom);
    queue_req(ils_pkg::OP_GET,    8'd255, 32'h0);
    queue_req(ils_pkg::OP_REMOVE, 8'd255, 32'h0);
    queue_req(ils_pkg::OP_APPEND, 8'd0,   $urandom);
    queue_req(ils_pkg::OP_REMOVE, 8'd0,   32'h0);
    queue_req(ils_pkg::OP_REMOVE, 8'd128, 32'h0);
    queue_req(ils_pkg::OP_GET,    8'd0,   32'h0);
    repeat (10) queue_random();
    drain();

    // a quiet spell for anything late
    repeat (300) @(posedge clk_i);
    if (due_replies.size() != 0)
      flag_mismatch("results never seen", 32'(due_replies.size()), '0);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/ils_pkg.sv
sv/ils_store.sv
sv/ils_ctrl.sv
sv/indexed_list_shift_store.sv
tb/indexed_list_shift_store_tb.sv
